### sv/evlux_pkg.sv
// Shared types and constants for the lux-to-exposure pipeline.
// No dependencies; imported by every module of the block.
package evlux_pkg;

  localparam int LUX_W      = 25;
  localparam int ISO_W      = 16;
  localparam int AP_W       = 16;
  localparam int SH_W       = 32;
  localparam int EV_W       = 14;
  localparam int TOP_W      = 6;
  localparam int LOG_FRAC   = 12;
  localparam int MANT_W     = 31;
  localparam int ROOT_N     = 8;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 33;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int LOG2_45_Q12 = 22495;
  localparam logic [MANT_W-1:0] ONE_Q30 = MANT_W'(1) << 30;

  localparam logic signed [EV_W-1:0] EV_MIN = {1'b1, {(EV_W-1){1'b0}}};
  localparam logic signed [EV_W-1:0] EV_MAX = {1'b0, {(EV_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 8'd0,
    REG_ISO      = 8'd1,
    REG_APERTURE = 8'd2,
    REG_SHUTTER  = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic sat;
    logic dark;
  } flags_t;

  // Q1.30 values of 2^(2^-k), k = 1..8
  function automatic logic [MANT_W-1:0] root_step(input logic [2:0] k);
    logic [MANT_W-1:0] c;
    unique case (k)
      3'd0: c = 31'd1518500250;
      3'd1: c = 31'd1276901417;
      3'd2: c = 31'd1170923762;
      3'd3: c = 31'd1121280436;
      3'd4: c = 31'd1097253708;
      3'd5: c = 31'd1085434106;
      3'd6: c = 31'd1079572136;
      3'd7: c = 31'd1076653033;
      default: c = ONE_Q30;
    endcase
    return c;
  endfunction

endpackage

### sv/evlux_log2.sv
// Log2 front end: lux * iso, normalize, 12 squaring stages, EV in Q6.8.
// Depends on evlux_pkg.
module evlux_log2 import evlux_pkg::*; #(
  parameter int LUX_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [LUX_W-1:0]      lux,
  input  logic [ISO_W-1:0]      iso,
  output logic                  out_valid,
  output logic signed [EV_W-1:0] ev,
  output flags_t                flags
);

  localparam int X_W    = LUX_W + ISO_W;
  localparam int OFFSET = LUX_FRAC_BITS * 4096 + LOG2_45_Q12 - 8;  // -8 folds in rounding

  logic [X_W-1:0]   x;
  logic             x_dark;
  logic             x_vld;
  logic [ISO_W-1:0] iso_eff;

  assign iso_eff = (iso == '0) ? ISO_W'(1) : iso;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= 1'b0;
    end else if (en) begin
      x_vld <= in_valid;
    end
    if (en) begin
      x      <= X_W'(lux) * X_W'(iso_eff);
      x_dark <= (lux == '0);
    end
  end

  // leading one and normalize to Q1.30
  logic [TOP_W-1:0]  top_c;
  logic [X_W-1:0]    norm;
  logic [MANT_W-1:0] m_c;

  always_comb begin
    top_c = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x[i]) top_c = TOP_W'(i);
    end
    norm = x << (TOP_W'(X_W - 1) - top_c);
    m_c  = norm[X_W-1 -: MANT_W];
  end

  logic [MANT_W-1:0]   m    [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] frac [0:LOG_FRAC];
  logic [TOP_W-1:0]    top  [0:LOG_FRAC];
  logic                dark [0:LOG_FRAC];
  logic                vld  [0:LOG_FRAC];

  logic [2*MANT_W-1:0] sq     [0:LOG_FRAC-1];
  logic [MANT_W:0]     sq_hi  [0:LOG_FRAC-1];
  logic [MANT_W-1:0]   m_next [0:LOG_FRAC-1];

  always_comb begin
    for (int j = 0; j < LOG_FRAC; j++) begin
      sq[j]     = (2*MANT_W)'(m[j]) * (2*MANT_W)'(m[j]);
      sq_hi[j]  = sq[j][2*MANT_W-1:30];
      m_next[j] = sq_hi[j][MANT_W] ? sq_hi[j][MANT_W:1] : sq_hi[j][MANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= LOG_FRAC; j++) vld[j] <= 1'b0;
    end else if (en) begin
      vld[0] <= x_vld;
      for (int j = 0; j < LOG_FRAC; j++) vld[j+1] <= vld[j];
    end
    if (en) begin
      m[0]    <= m_c;
      frac[0] <= '0;
      top[0]  <= top_c;
      dark[0] <= x_dark;
      for (int j = 0; j < LOG_FRAC; j++) begin
        m[j+1]    <= m_next[j];
        frac[j+1] <= {frac[j][LOG_FRAC-2:0], sq_hi[j][MANT_W]};
        top[j+1]  <= top[j];
        dark[j+1] <= dark[j];
      end
    end
  end

  // EV_q12 - offset, floor to Q.8, clamp
  logic signed [20:0] ev12;
  logic signed [20:0] ev8w;

  assign ev12 = signed'(21'({top[LOG_FRAC], frac[LOG_FRAC]})) - signed'(21'(OFFSET));
  assign ev8w = ev12 >>> 4;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LOG_FRAC];
    end
    if (en) begin
      flags.dark <= dark[LOG_FRAC];
      if (dark[LOG_FRAC]) begin
        ev        <= EV_MIN;
        flags.sat <= 1'b0;
      end else if (ev8w > 21'sd8191) begin
        ev        <= EV_MAX;
        flags.sat <= 1'b1;
      end else if (ev8w < -21'sd8192) begin
        ev        <= EV_MIN;
        flags.sat <= 1'b1;
      end else begin
        ev        <= ev8w[EV_W-1:0];
        flags.sat <= 1'b0;
      end
    end
  end

endmodule

### sv/evlux_exp.sv
// 2^EV mantissa: eight conditional Q1.30 multiply stages.
// Depends on evlux_pkg.
module evlux_exp import evlux_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [EV_W-1:0] ev_in,
  input  flags_t                 flags_in,
  output logic                   out_valid,
  output logic [MANT_W-1:0]      p_out,
  output logic [TOP_W-1:0]       ipb_out,
  output logic signed [EV_W-1:0] ev_out,
  output flags_t                 flags_out
);

  logic [MANT_W-1:0]      p   [0:ROOT_N];
  logic [7:0]             f   [0:ROOT_N];
  logic [TOP_W-1:0]       ipb [0:ROOT_N];
  logic signed [EV_W-1:0] ev  [0:ROOT_N];
  flags_t                 fl  [0:ROOT_N];
  logic                   vld [0:ROOT_N];

  logic [2*MANT_W:0]  prod   [0:ROOT_N-1];
  logic [MANT_W-1:0]  p_next [0:ROOT_N-1];

  always_comb begin
    for (int k = 0; k < ROOT_N; k++) begin
      prod[k]   = (2*MANT_W+1)'(p[k]) * (2*MANT_W+1)'(root_step(3'(k)))
                  + ((2*MANT_W+1)'(1) << 29);
      p_next[k] = f[k][7-k] ? prod[k][MANT_W+29:30] : p[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ROOT_N; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 0; k < ROOT_N; k++) vld[k+1] <= vld[k];
    end
    if (en) begin
      // biased = ev + 8192: flip the sign bit
      p[0]   <= ONE_Q30;
      f[0]   <= ev_in[7:0];
      ipb[0] <= {~ev_in[EV_W-1], ev_in[EV_W-2:8]};
      ev[0]  <= ev_in;
      fl[0]  <= flags_in;
      for (int k = 0; k < ROOT_N; k++) begin
        p[k+1]   <= p_next[k];
        f[k+1]   <= f[k];
        ipb[k+1] <= ipb[k];
        ev[k+1]  <= ev[k];
        fl[k+1]  <= fl[k];
      end
    end
  end

  assign out_valid = vld[ROOT_N];
  assign p_out     = p[ROOT_N];
  assign ipb_out   = ipb[ROOT_N];
  assign ev_out    = ev[ROOT_N];
  assign flags_out = fl[ROOT_N];

endmodule

### sv/evlux_settle.sv
// Camera setting: aperture by 32-step square root or shutter by 33-step
// restoring division, one step per stage. Depends on evlux_pkg.
module evlux_settle import evlux_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   mode,
  input  logic [AP_W-1:0]        set_aperture,
  input  logic [SH_W-1:0]        set_shutter,
  input  logic                   in_valid,
  input  logic [MANT_W-1:0]      p_in,
  input  logic [TOP_W-1:0]       ipb_in,
  input  logic signed [EV_W-1:0] ev_in,
  input  flags_t                 flags_in,
  output logic                   out_valid,
  output logic signed [EV_W-1:0] ev,
  output logic [AP_W-1:0]        aperture,
  output logic [SH_W-1:0]        shutter,
  output flags_t                 flags
);

  localparam int PROD_W = MANT_W + SH_W;
  localparam int DVD_W  = 2*AP_W + 63;

  // stage A: products
  logic [PROD_W-1:0]      a_prod;
  logic [2*AP_W-1:0]      a_num;
  logic [MANT_W-1:0]      a_p;
  logic [TOP_W-1:0]       a_ipb;
  logic signed [EV_W-1:0] a_ev;
  flags_t                 a_fl;
  logic                   a_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
    if (en) begin
      a_prod <= PROD_W'(p_in) * PROD_W'(set_shutter);
      a_num  <= (2*AP_W)'(set_aperture) * (2*AP_W)'(set_aperture);
      a_p    <= p_in;
      a_ipb  <= ipb_in;
      a_ev   <= ev_in;
      a_fl   <= flags_in;
    end
  end

  // stage B: align operands; top code of ipb means a left shift by one of the product, a right shift of the dividend
  logic [63:0]      v_al;
  logic [DVD_W-1:0] dvd;
  logic [DVD_W-1:0] div_lim;
  logic             top_ipb;

  assign top_ipb = (a_ipb == {TOP_W{1'b1}});
  assign v_al    = top_ipb ? {a_prod, 1'b0} : 64'(a_prod) >> (6'd62 - a_ipb);
  assign dvd     = top_ipb ? DVD_W'(a_num >> 1) : DVD_W'(a_num) << (6'd62 - a_ipb);
  assign div_lim = DVD_W'(a_p) << DIV_STEPS;

  logic [63:0]            rem  [0:DIV_STEPS];
  logic [63:0]            res  [0:DIV_STEPS];
  logic [MANT_W-1:0]      dp   [0:DIV_STEPS];
  logic                   dsat [0:DIV_STEPS];
  logic signed [EV_W-1:0] sev  [0:DIV_STEPS];
  flags_t                 sfl  [0:DIV_STEPS];
  logic                   vld  [0:DIV_STEPS];

  logic [63:0] trial    [0:DIV_STEPS-1];
  logic [63:0] rem_next [0:DIV_STEPS-1];
  logic [63:0] res_next [0:DIV_STEPS-1];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (mode) begin
        if (k < SQRT_STEPS) begin
          trial[k] = res[k] + (64'(1) << (62 - 2*k));
          if (rem[k] >= trial[k]) begin
            rem_next[k] = rem[k] - trial[k];
            res_next[k] = (res[k] >> 1) + (64'(1) << (62 - 2*k));
          end else begin
            rem_next[k] = rem[k];
            res_next[k] = res[k] >> 1;
          end
        end else begin
          trial[k]    = '0;
          rem_next[k] = rem[k];
          res_next[k] = res[k];
        end
      end else begin
        trial[k] = 64'(dp[k]) << (DIV_STEPS - 1 - k);
        if (rem[k] >= trial[k]) begin
          rem_next[k] = rem[k] - trial[k];
          res_next[k] = {res[k][62:0], 1'b1};
        end else begin
          rem_next[k] = rem[k];
          res_next[k] = {res[k][62:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= a_vld;
      for (int k = 0; k < DIV_STEPS; k++) vld[k+1] <= vld[k];
    end
    if (en) begin
      dsat[0] <= (dvd >= div_lim);
      rem[0]  <= mode ? v_al : dvd[63:0];
      res[0]  <= '0;
      dp[0]   <= a_p;
      sev[0]  <= a_ev;
      sfl[0]  <= a_fl;
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem[k+1]  <= rem_next[k];
        res[k+1]  <= res_next[k];
        dp[k+1]   <= dp[k];
        dsat[k+1] <= dsat[k];
        sev[k+1]  <= sev[k];
        sfl[k+1]  <= sfl[k];
      end
    end
  end

  // output register with saturation
  logic [63:0] r_fin;
  assign r_fin = res[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DIV_STEPS];
    end
    if (en) begin
      ev         <= sev[DIV_STEPS];
      flags.dark <= sfl[DIV_STEPS].dark;
      if (mode) begin
        shutter <= set_shutter;
        if (r_fin > 64'(16'hFFFF)) begin
          aperture  <= '1;
          flags.sat <= 1'b1;
        end else begin
          aperture  <= r_fin[AP_W-1:0];
          flags.sat <= sfl[DIV_STEPS].sat;
        end
      end else begin
        aperture <= set_aperture;
        if (dsat[DIV_STEPS] || r_fin > 64'(32'hFFFF_FFFF)) begin
          shutter   <= '1;
          flags.sat <= 1'b1;
        end else begin
          shutter   <= r_fin[SH_W-1:0];
          flags.sat <= sfl[DIV_STEPS].sat;
        end
      end
    end
  end

endmodule

### sv/exposure_setting_from_lux.sv
// Incident-light exposure meter. Each lux reading (unsigned, LUX_FRAC_BITS
// fraction bits) yields one item: EV = log2(lux*iso/45) in signed Q6.8, plus
// the f-number (Q8.8) and shutter time (Q16.16 s); the one not set in the
// registers is computed from EV = log2(N^2/t). Clipped results set saturated;
// zero lux sets no_light and forces EV to its minimum.
// Rate: one item per clock unless the output stalls. The pipeline contains the
// 12-stage log2 squaring chain, 8 root-multiply stages and the 33-step
// restoring divide / square-root chain. A stalled output holds the whole
// pipe. Configuration writes are taken every cycle; change them only when
// no item is in flight.
// Depends on evlux_pkg, evlux_log2, evlux_exp, evlux_settle.
module exposure_setting_from_lux import evlux_pkg::*; #(
  parameter int LUX_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [24:0] lux_q8
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [63:0]           m_tdata,   // [13:0] ev_q8, [29:14] aperture_out_q8,
                                           // [61:30] shutter_out_q16, [62] saturated,
                                           // [63] no_light
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic             shutter_priority_mode;
  logic [ISO_W-1:0] film_speed_iso;
  logic [AP_W-1:0]  set_aperture_q8;
  logic [SH_W-1:0]  set_shutter_q16;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shutter_priority_mode <= 1'b0;
      film_speed_iso        <= ISO_W'(400);
      set_aperture_q8       <= AP_W'(1434);
      set_shutter_q16       <= SH_W'(524);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_MODE)     shutter_priority_mode <= cfg_data[0];
      if (cfg_index == REG_ISO)      film_speed_iso        <= cfg_data[ISO_W-1:0];
      if (cfg_index == REG_APERTURE) set_aperture_q8       <= cfg_data[AP_W-1:0];
      if (cfg_index == REG_SHUTTER)  set_shutter_q16       <= cfg_data[SH_W-1:0];
    end
  end

  // global advance: the output register is free or being drained
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic                   lg_vld;
  logic signed [EV_W-1:0] lg_ev;
  flags_t                 lg_fl;

  evlux_log2 #(.LUX_FRAC_BITS(LUX_FRAC_BITS)) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .lux       (s_tdata[LUX_W-1:0]),
    .iso       (film_speed_iso),
    .out_valid (lg_vld),
    .ev        (lg_ev),
    .flags     (lg_fl)
  );

  logic                   ex_vld;
  logic [MANT_W-1:0]      ex_p;
  logic [TOP_W-1:0]       ex_ipb;
  logic signed [EV_W-1:0] ex_ev;
  flags_t                 ex_fl;

  evlux_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (lg_vld),
    .ev_in     (lg_ev),
    .flags_in  (lg_fl),
    .out_valid (ex_vld),
    .p_out     (ex_p),
    .ipb_out   (ex_ipb),
    .ev_out    (ex_ev),
    .flags_out (ex_fl)
  );

  logic signed [EV_W-1:0] ev_q8;
  logic [AP_W-1:0]        aperture_out_q8;
  logic [SH_W-1:0]        shutter_out_q16;
  flags_t                 out_fl;

  evlux_settle u_settle (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .mode         (shutter_priority_mode),
    .set_aperture (set_aperture_q8),
    .set_shutter  (set_shutter_q16),
    .in_valid     (ex_vld),
    .p_in         (ex_p),
    .ipb_in       (ex_ipb),
    .ev_in        (ex_ev),
    .flags_in     (ex_fl),
    .out_valid    (m_tvalid),
    .ev           (ev_q8),
    .aperture     (aperture_out_q8),
    .shutter      (shutter_out_q16),
    .flags        (out_fl)
  );

  assign m_tdata = {out_fl.dark, out_fl.sat, shutter_out_q16, aperture_out_q8, ev_q8};

  // no light always reports minimum EV
  a_dark_ev_min: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_fl.dark) |-> (ev_q8 == EV_MIN))
    else $error("no_light item without minimum EV");

  // the set value is passed through unchanged
  a_ap_pass: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !shutter_priority_mode) |-> (aperture_out_q8 == set_aperture_q8))
    else $error("aperture not passed through");

  a_sh_pass: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && shutter_priority_mode) |-> (shutter_out_q16 == set_shutter_q16))
    else $error("shutter not passed through");

  // input side stalls whenever the output is held
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while pipe held");

endmodule

### tb/tb_exposure_setting_from_lux.sv
// Self-checking testbench for exposure_setting_from_lux: lux items in, one
// exposure result out per item, checked against a bit-exact predictor.
// Depends on evlux_pkg and the exposure_setting_from_lux RTL.
`timescale 1ns / 1ps

module tb_exposure_setting_from_lux;
  import evlux_pkg::*;

  localparam int FRAC = 8;        // lux fraction bits, matches the dut default
  localparam int DRAIN = 80;      // longer than the pipe latency

  typedef struct packed {
    logic signed [EV_W-1:0] ev;
    logic [AP_W-1:0]        ap;
    logic [SH_W-1:0]        sh;
    logic                   sat;
    logic                   dark;
  } reading_t;

  // directed row: lux, and optionally a result typed in by hand
  typedef struct {
    logic [LUX_W-1:0] lux;
    bit               typed;
    reading_t         want;
  } lux_row_t;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [31:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [63:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  exposure_setting_from_lux dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the block's registers
  bit              shadow_mode;
  logic [15:0]     shadow_iso;
  logic [15:0]     shadow_ap;
  logic [31:0]     shadow_sh;

  reading_t pending_readings[$];
  int       mismatches;
  bit       quiet_phase;      // no gaps on either side while set

  // Q1.30 values of 2^(2^-k), k = 1..8
  localparam longint unsigned HALF_STEPS[8] = '{
    64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
    64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033
  };
  localparam longint unsigned Q30 = 64'd1 << 30;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // log2 of x > 0 in Q.12: top bit, then 12 squarings of the Q1.30 mantissa
  function automatic longint log2_q12(longint unsigned x);
    int top;
    longint unsigned m;
    longint frac;
    top = 63;
    while (top > 0 && x[top] == 1'b0) top--;
    m = (top > 30) ? (x >> (top - 30)) : (x << (30 - top));
    frac = 0;
    for (int k = 0; k < 12; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 2 * Q30) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(top) * 4096 + frac;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic reading_t meter_predict(logic [LUX_W-1:0] lux);
    reading_t res;
    longint unsigned iso, p, num, q, rem, prod, v;
    longint ev12, t, e;
    int ip, s, sh_exp;
    logic [13:0] biased;
    logic [7:0] f;
    iso = (shadow_iso == 0) ? 1 : shadow_iso;
    res = '0;
    res.dark = (lux == 0);
    if (res.dark) begin
      res.ev = EV_MIN;
    end else begin
      ev12 = log2_q12(longint'(lux) * iso) - FRAC * 4096 - LOG2_45_Q12;
      t = ev12 + 8 + (64'sd1 << 20);
      e = t / 16 - 65536;
      if (e > 8191) begin
        e = 8191;
        res.sat = 1'b1;
      end else if (e < -8192) begin
        e = -8192;
        res.sat = 1'b1;
      end
      res.ev = e[EV_W-1:0];
    end
    // 2^EV as p * 2^(ip-30)
    biased = res.ev + 14'sd8192;
    ip = int'(biased[13:8]) - 32;
    f = biased[7:0];
    p = Q30;
    for (int k = 0; k < 8; k++)
      if (f[7-k]) p = (p * HALF_STEPS[k] + (Q30 >> 1)) >> 30;

    if (shadow_mode) begin
      prod = p * shadow_sh;
      sh_exp = ip - 30;
      v = (sh_exp >= 0) ? (prod << sh_exp) : (prod >> (-sh_exp));
      v = root_floor(v);
      if (v > 64'hFFFF) begin
        v = 64'hFFFF;
        res.sat = 1'b1;
      end
      res.ap = v[15:0];
      res.sh = shadow_sh;
    end else begin
      num = longint'(shadow_ap) * shadow_ap;
      s = 30 - ip;
      if (s < 0) begin
        q = num / (p << 1);
      end else begin
        q = num / p;
        rem = num % p;
        for (int k = 0; k < s && q <= 64'hFFFF_FFFF; k++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= p) begin
            rem = rem - p;
            q = q | 1;
          end
        end
      end
      if (q > 64'hFFFF_FFFF) begin
        q = 64'hFFFF_FFFF;
        res.sat = 1'b1;
      end
      res.sh = q[31:0];
      res.ap = shadow_ap;
    end
    return res;
  endfunction

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random lux: random width first so small readings show up often.
  function automatic logic [LUX_W-1:0] pick_lux();
    logic [LUX_W-1:0] mask;
    if ($urandom_range(49) == 0) return '0;
    mask = (LUX_W'(1) << $urandom_range(1, LUX_W - 1)) - LUX_W'(1);
    if ($urandom_range(3) == 0) mask = '1;
    return LUX_W'($urandom) & mask;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:     shadow_mode = value[0];
      REG_ISO:      shadow_iso  = value[15:0];
      REG_APERTURE: shadow_ap   = value[15:0];
      REG_SHUTTER:  shadow_sh   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Send one lux item; prediction is taken at the accepting edge.
  task automatic send_lux(logic [LUX_W-1:0] lux, bit typed, reading_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lux};
    do @(posedge clk); while (!s_tready);
    pending_readings.push_back(typed ? want : meter_predict(lux));
    @(negedge clk);
  endtask

  // Registers change only with the pipe empty.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // Output side: stalls on m_tready of random length.
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      stall = pick_gap();
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    reading_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.ev   = m_tdata[13:0];
      got.ap   = m_tdata[29:14];
      got.sh   = m_tdata[61:30];
      got.sat  = m_tdata[62];
      got.dark = m_tdata[63];
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = pending_readings.pop_front();
        if (got.ev !== want.ev || got.ap !== want.ap || got.sh !== want.sh ||
            got.sat !== want.sat || got.dark !== want.dark) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch ev %0d/%0d ap %0d/%0d sh %0d/%0d sat %b/%b dark %b/%b",
                     got.ev, want.ev, got.ap, want.ap, got.sh, want.sh,
                     got.sat, want.sat, got.dark, want.dark);
        end
      end
    end
  end

  // Hard stop.
  initial begin
    #20ms;
    $display("[exposure_setting_from_lux] ERROR");
    $finish;
  end

  initial begin
    lux_row_t rows[$];
    lux_row_t row;
    reading_t none;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    quiet_phase = 1'b0;
    shadow_mode = 1'b0;
    shadow_iso = 16'd400;
    shadow_ap = 16'd1434;
    shadow_sh = 32'd524;
    none = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero lux at reset settings; aperture priority pushes the
    // shutter to its ceiling.
    row.lux = '0;
    row.typed = 1'b1;
    row.want = '{ev: EV_MIN, ap: 16'd1434, sh: 32'hFFFF_FFFF, sat: 1'b1, dark: 1'b1};
    rows.push_back(row);
    row.typed = 1'b0;
    row.want = none;
    foreach (HALF_STEPS[i]) begin
      row.lux = LUX_W'(1) << (3 * i);
      rows.push_back(row);
    end
    row.lux = 25'd1;              rows.push_back(row);
    row.lux = 25'd256;            rows.push_back(row);
    row.lux = 25'h1FF_FFFF;       rows.push_back(row);
    row.lux = 25'h155_5555;       rows.push_back(row);
    row.lux = 25'h0AA_AAAA;       rows.push_back(row);
    row.lux = 25'h100_0000;       rows.push_back(row);
    foreach (rows[i]) send_lux(rows[i].lux, rows[i].typed, rows[i].want);

    // Extremes in both modes, plus an unused register index.
    wait_idle();
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_SHUTTER, 32'hFFFF_FFFF);
    write_reg(REG_ISO, 32'd65535);
    write_reg(cfg_reg_t'(8'd200), 32'hFFFF_FFFF);
    foreach (rows[i]) send_lux(rows[i].lux, 1'b0, none);
    wait_idle();
    write_reg(REG_SHUTTER, 32'd0);
    write_reg(REG_ISO, 32'd0);
    send_lux(25'h1FF_FFFF, 1'b0, none);
    send_lux(25'd1, 1'b0, none);
    wait_idle();
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_APERTURE, 32'd0);
    send_lux(25'h1FF_FFFF, 1'b0, none);
    send_lux(25'd0, 1'b0, none);
    wait_idle();
    write_reg(REG_APERTURE, 32'hFFFF);
    write_reg(REG_ISO, 32'd1);
    foreach (rows[i]) send_lux(rows[i].lux, 1'b0, none);

    // Random phases, each with fresh settings.
    for (int ph = 0; ph < 14; ph++) begin
      wait_idle();
      quiet_phase = ($urandom_range(3) == 0);
      write_reg(REG_MODE, $urandom_range(1));
      case ($urandom_range(3))
        0: write_reg(REG_ISO, 32'd1);
        1: write_reg(REG_ISO, 32'd65535);
        default: write_reg(REG_ISO, $urandom_range(1, 65535));
      endcase
      case ($urandom_range(3))
        0: write_reg(REG_APERTURE, 32'd128);
        1: write_reg(REG_APERTURE, 32'd65535);
        default: write_reg(REG_APERTURE, $urandom_range(128, 65535));
      endcase
      case ($urandom_range(3))
        0: write_reg(REG_SHUTTER, 32'd1);
        1: write_reg(REG_SHUTTER, 32'hFFFF_FFFF);
        default: write_reg(REG_SHUTTER, $urandom >> $urandom_range(31));
      endcase
      repeat (105) send_lux(pick_lux(), 1'b0, none);
    end

    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0)
      $display("[exposure_setting_from_lux] OK");
    else
      $display("[exposure_setting_from_lux] ERROR");
    $finish;
  end

endmodule
